/* rtl/bwba_pkg.sv */
package bwba_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned CmdW = 2;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [AddrW-1:0] LowGuard = 64'h0000_0000_0000_1000;

  localparam logic [CmdW-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CmdW-1:0] CMD_XLATE   = 2'd1;
  localparam logic [CmdW-1:0] CMD_RESTART = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_MEM_BUS     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MEM_PHYS    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MEM_SIZE    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MEM64_BUS   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MEM64_PHYS  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MEM64_SIZE  = 3'd5;

  typedef struct packed {
    logic load;
    logic step1;
    logic step2;
    logic step3;
    logic finish;
  } bwba_ctrl_t;

  typedef struct packed {
    logic out_blocked;
  } bwba_stat_t;

endpackage

/* rtl/bwba_ctrl.sv */
module bwba_ctrl
  import bwba_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  bwba_stat_t stat,
  output bwba_ctrl_t ctrl
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_S1   = 3'd1;
  localparam logic [2:0] ST_S2   = 3'd2;
  localparam logic [2:0] ST_S3   = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctrl = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_nxt = ST_S1;
        end
      end
      ST_S1: begin
        ctrl.step1 = 1'b1;
        state_nxt = ST_S2;
      end
      ST_S2: begin
        ctrl.step2 = 1'b1;
        state_nxt = ST_S3;
      end
      ST_S3: begin
        ctrl.step3 = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the result
        if (!stat.out_blocked) begin
          ctrl.finish = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/bwba_dp.sv */
module bwba_dp
  import bwba_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  bwba_ctrl_t         ctrl,
  output bwba_stat_t         stat,
  input  logic [CmdW-1:0]    in_cmd,
  input  logic               in_want_mem64,
  input  logic [AddrW-1:0]   in_bar_size,
  input  logic [AddrW-1:0]   in_bus_addr,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [AddrW-1:0]   cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic [AddrW-1:0]   out_address,
  output logic               out_window_used
);

  logic [AddrW-1:0] mem_bus_r, mem_phys_r, mem_size_r;
  logic [AddrW-1:0] m64_bus_r, m64_phys_r, m64_size_r;
  logic [AddrW-1:0] mem_off_r, mem_off_nxt;
  logic [AddrW-1:0] m64_off_r, m64_off_nxt;

  logic [CmdW-1:0]  cmd_r;
  logic             want_r;
  logic [AddrW-1:0] bar_r, bus_r;
  logic [AddrW-1:0] t_r, addr_r, end_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [AddrW-1:0] out_addr_r, out_addr_nxt;
  logic             out_win_r, out_win_nxt;

  logic             use64;
  logic [AddrW-1:0] start_s, phys_s, size_s, off_s;
  logic             no_window, fits;

  assign use64   = want_r && (m64_size_r != '0);
  assign start_s = use64 ? m64_bus_r : mem_bus_r;
  assign phys_s  = use64 ? m64_phys_r : mem_phys_r;
  assign size_s  = use64 ? m64_size_r : mem_size_r;
  assign off_s   = use64 ? m64_off_r : mem_off_r;

  assign no_window = want_r && (m64_size_r == '0) && (mem_size_r == '0);
  assign fits      = !(end_r > size_s);

  assign stat.out_blocked = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_bus_r  <= '0;
      mem_phys_r <= '0;
      mem_size_r <= '0;
      m64_bus_r  <= '0;
      m64_phys_r <= '0;
      m64_size_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MEM_BUS:    mem_bus_r  <= cfg_data;
        REG_MEM_PHYS:   mem_phys_r <= cfg_data;
        REG_MEM_SIZE:   mem_size_r <= cfg_data;
        REG_MEM64_BUS:  m64_bus_r  <= cfg_data;
        REG_MEM64_PHYS: m64_phys_r <= cfg_data;
        REG_MEM64_SIZE: m64_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand capture and the three add steps
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r  <= in_cmd;
      want_r <= in_want_mem64;
      bar_r  <= in_bar_size;
      bus_r  <= in_bus_addr;
    end
    if (ctrl.step1) begin
      if (cmd_r == CMD_XLATE) t_r <= bus_r - start_s;
      else                    t_r <= start_s + off_s - {{(AddrW-1){1'b0}}, 1'b1};
    end
    if (ctrl.step2) begin
      if (cmd_r == CMD_XLATE) addr_r <= phys_s + t_r;
      else addr_r <= (t_r | (bar_r - {{(AddrW-1){1'b0}}, 1'b1}))
                     + {{(AddrW-1){1'b0}}, 1'b1};
    end
    if (ctrl.step3) begin
      end_r <= addr_r - start_s + bar_r;
    end
  end

  always_comb begin
    mem_off_nxt   = mem_off_r;
    m64_off_nxt   = m64_off_r;
    out_ok_nxt    = out_ok_r;
    out_addr_nxt  = out_addr_r;
    out_win_nxt   = out_win_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (ctrl.finish) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = 1'b0;
      out_addr_nxt  = '0;
      out_win_nxt   = 1'b0;
      unique case (cmd_r)
        CMD_ALLOC: begin
          if (!no_window) begin
            out_win_nxt = use64;
            if (fits) begin
              out_ok_nxt   = 1'b1;
              out_addr_nxt = addr_r;
              if (use64) m64_off_nxt = end_r;
              else       mem_off_nxt = end_r;
            end
          end
        end
        CMD_XLATE: begin
          if (bus_r != '0) begin
            out_ok_nxt   = 1'b1;
            out_addr_nxt = addr_r;
            out_win_nxt  = use64;
          end
        end
        CMD_RESTART: begin
          out_ok_nxt  = 1'b1;
          mem_off_nxt = (mem_bus_r < LowGuard) ? LowGuard : '0;
          m64_off_nxt = (m64_bus_r < LowGuard) ? LowGuard : '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mem_off_r   <= '0;
      m64_off_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      mem_off_r   <= mem_off_nxt;
      m64_off_r   <= m64_off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r   <= out_ok_nxt;
    out_addr_r <= out_addr_nxt;
    out_win_r  <= out_win_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_address     = out_addr_r;
  assign out_window_used = out_win_r;

endmodule

/* rtl/bar_window_bump_allocator_core.sv */
// one item in flight: a new input is taken only in the idle state (capture); the
//   item then runs the three dependent 64-bit add steps S1, S2, S3 that share one
//   datapath, then FIN, which registers the result and holds while the last result waits on out_ready
// reset (rst_n low, synchronous): controller idle, output empty, window registers
//   and both allocation offsets cleared to zero
module bar_window_bump_allocator_core
  import bwba_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CmdW-1:0]    in_cmd,
  input  logic               in_want_mem64,
  input  logic [AddrW-1:0]   in_bar_size,
  input  logic [AddrW-1:0]   in_bus_addr,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [AddrW-1:0]   cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic [AddrW-1:0]   out_address,
  output logic               out_window_used
);

  bwba_ctrl_t ctrl;
  bwba_stat_t stat;

  assign cfg_ready = 1'b1;

  bwba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  bwba_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .in_cmd          (in_cmd),
    .in_want_mem64   (in_want_mem64),
    .in_bar_size     (in_bar_size),
    .in_bus_addr     (in_bus_addr),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_address     (out_address),
    .out_window_used (out_window_used)
  );

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // a failed command never reports an address
  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_address == '0)
    else $error("failed result carries an address");

  // a new result only appears while the controller is busy finishing
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result produced without a pending item");

endmodule

/* tb/bar_window_bump_allocator_core_tb.sv */
module bar_window_bump_allocator_core_tb;
  import bwba_pkg::*;

  localparam logic [CmdW-1:0]    CMD_UNUSED = 2'd3;
  localparam logic [CfgIdxW-1:0] REG_SPARE  = 3'd7;
  localparam logic [AddrW-1:0]   AllOnes    = '1;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned PhaseItems = 115;
  localparam int unsigned NumPhases  = 10;

  typedef struct packed {
    logic             ok;
    logic [AddrW-1:0] address;
    logic             window_used;
  } resp_t;

  typedef struct {
    bit                 is_cfg;
    bit                 fixed;
    logic [CfgIdxW-1:0] idx;
    logic [AddrW-1:0]   data;
    logic [CmdW-1:0]    cmd;
    logic               want;
    logic [AddrW-1:0]   bar;
    logic [AddrW-1:0]   bus;
    resp_t              resp;
  } plan_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_RARE} rx_mode_t;
  typedef enum logic [2:0] {
    WIN_ABSENT, WIN_TYPICAL, WIN_SATURATED, WIN_MEM_ONLY, WIN_RANDOM, WIN_LOW
  } win_profile_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CmdW-1:0]    in_cmd = CMD_ALLOC;
  logic               in_want_mem64 = 1'b0;
  logic [AddrW-1:0]   in_bar_size = '0;
  logic [AddrW-1:0]   in_bus_addr = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = REG_MEM_BUS;
  logic [AddrW-1:0]   cfg_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_ok;
  logic [AddrW-1:0]   out_address;
  logic               out_window_used;

  bar_window_bump_allocator_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_want_mem64   (in_want_mem64),
    .in_bar_size     (in_bar_size),
    .in_bus_addr     (in_bus_addr),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_address     (out_address),
    .out_window_used (out_window_used)
  );

  initial forever #5 clk = ~clk;

  // window registers and allocation offsets as the block should hold them
  logic [AddrW-1:0] win_mem_bus = '0;
  logic [AddrW-1:0] win_mem_phys = '0;
  logic [AddrW-1:0] win_mem_size = '0;
  logic [AddrW-1:0] win64_bus = '0;
  logic [AddrW-1:0] win64_phys = '0;
  logic [AddrW-1:0] win64_size = '0;
  logic [AddrW-1:0] next_mem_off = '0;
  logic [AddrW-1:0] next_win64_off = '0;

  resp_t       pending_resp[$];
  plan_row_t   plan[$];
  resp_t       exp_r;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit          no_gaps = 1'b0;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;

  function automatic resp_t allocator_response(input logic [CmdW-1:0] cmd, input logic want,
                                               input logic [AddrW-1:0] bar,
                                               input logic [AddrW-1:0] bus);
    resp_t            r;
    logic             use64;
    logic [AddrW-1:0] start, phys, size, offs, addr, fin;
    r = '0;
    use64 = want && (win64_size != '0);
    start = use64 ? win64_bus : win_mem_bus;
    phys  = use64 ? win64_phys : win_mem_phys;
    size  = use64 ? win64_size : win_mem_size;
    offs  = use64 ? next_win64_off : next_mem_off;
    case (cmd)
      CMD_ALLOC: begin
        // asking for the 64-bit window with neither window present
        if (!(want && win64_size == '0 && win_mem_size == '0)) begin
          addr = ((start + offs - 64'd1) | (bar - 64'd1)) + 64'd1;
          fin = addr - start + bar;
          r.window_used = use64;
          if (fin <= size) begin
            if (use64) next_win64_off = fin;
            else next_mem_off = fin;
            r.ok = 1'b1;
            r.address = addr;
          end
        end
      end
      CMD_XLATE: begin
        if (bus != '0) begin
          r.ok = 1'b1;
          r.address = phys + (bus - start);
          r.window_used = use64;
        end
      end
      CMD_RESTART: begin
        next_mem_off = (win_mem_bus < LowGuard) ? LowGuard : '0;
        next_win64_off = (win64_bus < LowGuard) ? LowGuard : '0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [AddrW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void plan_cfg(input logic [CfgIdxW-1:0] idx, input logic [AddrW-1:0] data);
    plan_row_t row;
    row = '{is_cfg: 1'b1, fixed: 1'b0, idx: idx, data: data, cmd: CMD_ALLOC, want: 1'b0,
            bar: '0, bus: '0, resp: '0};
    plan.push_back(row);
  endfunction

  function automatic void plan_item(input logic [CmdW-1:0] cmd, input logic want,
                                    input logic [AddrW-1:0] bar, input logic [AddrW-1:0] bus);
    plan_row_t row;
    row = '{is_cfg: 1'b0, fixed: 1'b0, idx: REG_MEM_BUS, data: '0, cmd: cmd, want: want,
            bar: bar, bus: bus, resp: '0};
    plan.push_back(row);
  endfunction

  function automatic void plan_fixed(input logic [CmdW-1:0] cmd, input logic want,
                                     input logic [AddrW-1:0] bar, input logic [AddrW-1:0] bus,
                                     input logic ok, input logic [AddrW-1:0] addr,
                                     input logic win);
    plan_row_t row;
    row = '{is_cfg: 1'b0, fixed: 1'b1, idx: REG_MEM_BUS, data: '0, cmd: cmd, want: want,
            bar: bar, bus: bus, resp: '{ok: ok, address: addr, window_used: win}};
    plan.push_back(row);
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_resp.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [AddrW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MEM_BUS:    win_mem_bus = data;
      REG_MEM_PHYS:   win_mem_phys = data;
      REG_MEM_SIZE:   win_mem_size = data;
      REG_MEM64_BUS:  win64_bus = data;
      REG_MEM64_PHYS: win64_phys = data;
      REG_MEM64_SIZE: win64_size = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(input logic [CmdW-1:0] cmd, input logic want,
                              input logic [AddrW-1:0] bar, input logic [AddrW-1:0] bus,
                              input bit fixed, input resp_t fixed_resp);
    int unsigned gap;
    resp_t       r;
    if (burst_left == 0) begin
      if (no_gaps) gap = 0;
      else if ($urandom_range(0, 7) == 0) gap = $urandom_range(8, 25);
      else gap = $urandom_range(0, 3);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_want_mem64 <= want;
    in_bar_size   <= bar;
    in_bus_addr   <= bus;
    do @(posedge clk); while (!in_ready);
    r = allocator_response(cmd, want, bar, bus);
    pending_resp.push_back(fixed ? fixed_resp : r);
  endtask

  task automatic program_windows(input win_profile_t prof);
    logic [AddrW-1:0] mb, mp, ms, xb, xp, xs;
    mb = '0; mp = '0; ms = '0; xb = '0; xp = '0; xs = '0;
    case (prof)
      WIN_TYPICAL: begin
        mb = {32'h0, $urandom & 32'hffff_f000};
        mp = rand64();
        ms = 64'h4_0000;
        xb = {$urandom & 32'h0000_ffff, 32'h0};
        xp = rand64();
        xs = 64'h10_0000;
      end
      WIN_SATURATED: begin
        mb = AllOnes; mp = AllOnes; ms = AllOnes;
        xb = AllOnes; xp = AllOnes; xs = AllOnes;
      end
      WIN_MEM_ONLY: begin
        mp = rand64();
        ms = 64'h2_0000;
        xb = rand64();
        xp = rand64();
      end
      WIN_RANDOM: begin
        mb = rand64(); mp = rand64(); ms = rand64();
        xb = rand64(); xp = rand64(); xs = rand64();
      end
      WIN_LOW: begin
        // starts under the low guard page
        mb = 64'($urandom_range(0, 32'hfff));
        mp = rand64();
        ms = 64'h1_0000;
        xb = 64'($urandom_range(0, 32'hfff));
        xp = rand64();
        xs = 64'h8000;
      end
      default: ;
    endcase
    drain_results();
    write_reg(REG_MEM_BUS, mb);
    write_reg(REG_MEM_PHYS, mp);
    write_reg(REG_MEM_SIZE, ms);
    write_reg(REG_MEM64_BUS, xb);
    write_reg(REG_MEM64_PHYS, xp);
    write_reg(REG_MEM64_SIZE, xs);
  endtask

  task automatic random_request();
    int unsigned      pick, kind;
    logic [CmdW-1:0]  cmd;
    logic             want;
    logic [AddrW-1:0] bar, bus, start;
    pick = $urandom_range(0, 99);
    kind = $urandom_range(0, 19);
    want = 1'($urandom_range(0, 1));
    bar  = rand64();
    bus  = rand64();
    if (pick < 55) begin
      cmd = CMD_ALLOC;
      if (kind < 15) bar = 64'd1 << $urandom_range(0, 14);
      else if (kind < 18) bar = 64'd1 << $urandom_range(15, 63);
      else if (kind == 18) bar = ($urandom_range(0, 1) != 0) ? '0 : AllOnes;
    end else if (pick < 85) begin
      cmd = CMD_XLATE;
      start = (want && win64_size != '0) ? win64_bus : win_mem_bus;
      if (kind < 14) bus = start + $urandom_range(0, 32'h000f_ffff);
      else if (kind < 16) bus = '0;
    end else if (pick < 95) begin
      cmd = CMD_RESTART;
    end else begin
      cmd = CMD_UNUSED;
    end
    send_request(cmd, want, bar, bus, 1'b0, '0);
  endtask

  // receiver readiness follows its own slowly changing pattern
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(32, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= (cycles[1:0] == 2'd0);
      default:   out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_resp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result ok=%0b address=%h window_used=%0b",
                 $time, out_ok, out_address, out_window_used);
      end else begin
        exp_r = pending_resp.pop_front();
        if (out_ok !== exp_r.ok) begin
          errors++;
          $display("%0t: ok expected %0b actual %0b", $time, exp_r.ok, out_ok);
        end
        if (out_address !== exp_r.address) begin
          errors++;
          $display("%0t: address expected %h actual %h", $time, exp_r.address, out_address);
        end
        if (out_window_used !== exp_r.window_used) begin
          errors++;
          $display("%0t: window_used expected %0b actual %0b",
                   $time, exp_r.window_used, out_window_used);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("bar_window_bump_allocator_core verification failed");
      $finish;
    end
  end

  initial begin
    win_profile_t phase_plan[NumPhases];
    phase_plan = '{WIN_TYPICAL, WIN_MEM_ONLY, WIN_LOW, WIN_SATURATED, WIN_TYPICAL,
                   WIN_RANDOM, WIN_ABSENT, WIN_LOW, WIN_TYPICAL, WIN_MEM_ONLY};

    // windows absent right after reset
    plan_fixed(CMD_ALLOC, 1'b0, 64'h1000, '0, 1'b0, '0, 1'b0);
    plan_fixed(CMD_ALLOC, 1'b1, 64'h10, '0, 1'b0, '0, 1'b0);
    plan_fixed(CMD_XLATE, 1'b0, '0, '0, 1'b0, '0, 1'b0);
    plan_fixed(CMD_UNUSED, 1'b0, '0, '0, 1'b0, '0, 1'b0);
    plan_fixed(CMD_RESTART, 1'b0, '0, '0, 1'b1, '0, 1'b0);
    plan_fixed(CMD_XLATE, 1'b1, '0, AllOnes, 1'b1, AllOnes, 1'b0);
    // zero size: mask of all ones rounds to zero, end lands on zero and fits
    plan_fixed(CMD_ALLOC, 1'b0, '0, '0, 1'b1, '0, 1'b0);

    plan_cfg(REG_MEM_BUS, 64'h8000_0000);
    plan_cfg(REG_MEM_PHYS, 64'h0000_0040_0000_0000);
    plan_cfg(REG_MEM_SIZE, 64'h0010_0000);
    plan_cfg(REG_MEM64_BUS, 64'h0000_0080_0000_0000);
    plan_cfg(REG_MEM64_PHYS, 64'hffff_ff00_0000_0000);
    plan_cfg(REG_MEM64_SIZE, 64'h1_0000_0000);
    plan_cfg(REG_SPARE, AllOnes);
    plan_fixed(CMD_RESTART, 1'b1, '0, '0, 1'b1, '0, 1'b0);
    plan_item(CMD_ALLOC, 1'b0, 64'h1000, '0);
    plan_item(CMD_ALLOC, 1'b0, 64'h1, '0);
    plan_item(CMD_ALLOC, 1'b0, 64'h3000, '0);
    plan_item(CMD_ALLOC, 1'b0, 64'h8000_0000_0000_0000, '0);
    plan_item(CMD_ALLOC, 1'b0, AllOnes, '0);
    plan_item(CMD_ALLOC, 1'b1, 64'h10_0000, '0);
    plan_item(CMD_ALLOC, 1'b1, 64'h8000_0000, '0);
    plan_item(CMD_ALLOC, 1'b1, 64'h1_0000_0000, '0);
    plan_item(CMD_XLATE, 1'b0, '0, 64'h8000_1234);
    plan_item(CMD_XLATE, 1'b1, '0, 64'h0000_0080_0000_5000);
    plan_item(CMD_XLATE, 1'b1, '0, 64'h1);
    plan_item(CMD_XLATE, 1'b0, '0, AllOnes);
    plan_fixed(CMD_UNUSED, 1'b1, AllOnes, AllOnes, 1'b0, '0, 1'b0);
    // 64-bit window gone: requests fall back to the memory window
    plan_cfg(REG_MEM64_SIZE, '0);
    plan_item(CMD_ALLOC, 1'b1, 64'h100, '0);
    plan_cfg(REG_MEM_BUS, 64'h800);
    plan_fixed(CMD_RESTART, 1'b0, '0, '0, 1'b1, '0, 1'b0);
    plan_item(CMD_ALLOC, 1'b0, 64'h1000, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_request(plan[i].cmd, plan[i].want, plan[i].bar, plan[i].bus,
                     plan[i].fixed, plan[i].resp);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      program_windows(phase_plan[p]);
      no_gaps = (p % 4 == 2);
      for (int k = 0; k < PhaseItems; k++) begin
        // hold off mid-phase until the block has handed back everything
        if (k == PhaseItems / 2) drain_results();
        random_request();
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_resp.size() == 0) begin
      $display("bar_window_bump_allocator_core verification clean");
    end else begin
      $display("bar_window_bump_allocator_core verification failed");
    end
    $finish;
  end

endmodule
